/* sv/ksnc_pkg.sv */
`default_nettype none
package ksnc_pkg;

  localparam int KEY_COUNT = 64;
  localparam int KEY_W     = 6;
  localparam int KEY_AW    = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int KEY_EXT_W = KEY_W + KEY_AW;
  localparam int RD_W      = 8;
  localparam int CFG_IDX_W = 1;
  localparam int DIV_STEPS = RD_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  localparam logic [1:0] KIND_CLEAR   = 2'd0;
  localparam logic [1:0] KIND_IDLE    = 2'd1;
  localparam logic [1:0] KIND_PRESSED = 2'd2;
  localparam logic [1:0] KIND_COMPUTE = 2'd3;

  localparam logic [1:0] GRADE_POOR = 2'd0;
  localparam logic [1:0] GRADE_FAIR = 2'd1;
  localparam logic [1:0] GRADE_GOOD = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GOOD_SNR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAIR_SNR = 1'd1;

  localparam logic [RD_W-1:0] GOOD_RESET = 8'd20;
  localparam logic [RD_W-1:0] FAIR_RESET = 8'd10;

  typedef struct packed {
    logic [RD_W-1:0] idle_min;
    logic [RD_W-1:0] idle_max;
    logic [RD_W-1:0] pressed_max;
  } ksnc_entry_t;

  localparam ksnc_entry_t ENTRY_RESET = '{idle_min: 8'hFF, idle_max: 8'h00, pressed_max: 8'h00};

  typedef struct packed {
    logic            start;
    logic            neg;
    logic [RD_W-1:0] mag;
    logic [RD_W-1:0] divisor;
  } ksnc_div_req_t;

endpackage
`default_nettype wire

/* sv/ksnc_in_if.sv */
`default_nettype none
interface ksnc_in_if import ksnc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [KEY_W-1:0] key;
  logic [RD_W-1:0]  reading;

  modport source (output valid, kind, key, reading, input ready);
  modport sink (input valid, kind, key, reading, output ready);
endinterface
`default_nettype wire

/* sv/ksnc_out_if.sv */
`default_nettype none
interface ksnc_out_if import ksnc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_out;
  logic [RD_W-1:0]  low_level;
  logic [RD_W-1:0]  high_level;
  logic [RD_W-1:0]  noise_level;
  logic [RD_W-1:0]  snr;
  logic [1:0]       grade;

  modport source (output valid, key_out, low_level, high_level, noise_level, snr, grade,
                  input ready);
  modport sink (input valid, key_out, low_level, high_level, noise_level, snr, grade,
                output ready);
endinterface
`default_nettype wire

/* sv/ksnc_cfg_if.sv */
`default_nettype none
interface ksnc_cfg_if import ksnc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [RD_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/ksnc_store.sv */
`default_nettype none
module ksnc_store import ksnc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              clear,
  input  wire logic              rd_en,
  input  wire logic [KEY_AW-1:0] rd_addr,
  output ksnc_entry_t            rd_data,
  input  wire logic              wr_en,
  input  wire logic [KEY_AW-1:0] wr_addr,
  input  ksnc_entry_t            wr_data
);

  ksnc_entry_t          mem_r [KEY_COUNT];
  logic [KEY_COUNT-1:0] valid_r;
  ksnc_entry_t          rd_data_r;
  logic                 rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // an entry never written since reset or clear reads as its reset value
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : ENTRY_RESET;

endmodule
`default_nettype wire

/* sv/ksnc_div.sv */
`default_nettype none
module ksnc_div import ksnc_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  ksnc_div_req_t        req,
  output logic                 busy,
  output logic [RD_W-1:0]      quotient
);

  logic              busy_r, busy_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [RD_W-1:0]   rem_r, rem_nxt;
  logic [RD_W-1:0]   quo_r, quo_nxt;
  logic [RD_W-1:0]   div_r, div_nxt;
  logic              neg_r, neg_nxt;
  logic [RD_W:0]     trial;

  // restoring division, one quotient bit a cycle, msb first
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    trial    = {rem_r, quo_r[RD_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CW'(DIV_STEPS - 1);
      rem_nxt  = '0;
      quo_nxt  = req.mag;
      div_nxt  = req.divisor;
      neg_nxt  = req.neg;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = RD_W'(trial - {1'b0, div_r});
        quo_nxt = {quo_r[RD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[RD_W-1:0];
        quo_nxt = {quo_r[RD_W-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
    neg_r <= neg_nxt;
  end

  assign busy     = busy_r;
  assign quotient = neg_r ? RD_W'(-quo_r) : quo_r;

endmodule
`default_nettype wire

/* sv/key_sensor_noise_calibration.sv */
// Per-key calibration tracker for an analog key matrix. Each key has an entry in one
// synchronous memory holding its idle minimum, idle maximum and pressed maximum. Item kinds:
// clear (all entries return to idle min 0xFF, maxima 0; thresholds kept), idle sample,
// pressed sample, and compute, which returns one result with noise = idle spread (never 0),
// low/high levels = idle max / pressed max (raised to idle max) minus half the noise,
// snr = (high - low) / noise truncated toward zero, low 8 bits, and a grade of poor, fair
// or good against the two threshold registers (strictly greater than). Keys at or beyond
// the key count are ignored and give no result. Steps: a clear drops the per-entry valid
// bits at once, with no sweep; a sample is the memory read and then the write-back; a
// compute is the memory read, then the bit-serial divider (one quotient bit a cycle), then
// the result register load, which waits for that register to empty. Results leave through
// a result register, so the next item is taken while one waits.
`default_nettype none
module key_sensor_noise_calibration import ksnc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ksnc_in_if.sink     in_ch,
  ksnc_out_if.source  out_ch,
  ksnc_cfg_if.sink    cfg_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RMW  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [1:0]       kind_r;
  logic [KEY_W-1:0] key_r;
  logic [RD_W-1:0]  reading_r;

  // thresholds
  logic [RD_W-1:0] good_thr_r;
  logic [RD_W-1:0] fair_thr_r;

  // compute operands held while the divider runs
  logic [RD_W-1:0] low_r, high_r, noise_r;

  // result register
  logic             out_valid_r;
  logic [KEY_W-1:0] out_key_r;
  logic [RD_W-1:0]  out_low_r, out_high_r, out_noise_r, out_snr_r;
  logic [1:0]       out_grade_r;

  logic                 in_acc;
  logic [KEY_EXT_W-1:0] key_ext;
  logic                 key_ok;
  logic                 store_clear;
  logic                 rd_en;
  ksnc_entry_t          entry;
  ksnc_entry_t          entry_upd;
  logic                 wr_en;

  logic [RD_W-1:0] noise_raw, noise, pmax, half, low_v, high_v;
  logic [RD_W:0]   diff;
  ksnc_div_req_t   div_req;
  logic            div_busy;
  logic [RD_W-1:0] quotient;
  logic            out_free;
  logic            load_out;
  logic [1:0]      grade_v;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign key_ext      = KEY_EXT_W'(in_ch.key);
  assign key_ok       = key_ext < KEY_EXT_W'(KEY_COUNT);
  assign store_clear  = in_acc && (in_ch.kind == KIND_CLEAR);
  assign rd_en        = in_acc && (in_ch.kind != KIND_CLEAR) && key_ok;

  ksnc_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (store_clear),
    .rd_en   (rd_en),
    .rd_addr (key_ext[KEY_AW-1:0]),
    .rd_data (entry),
    .wr_en   (wr_en),
    .wr_addr (KEY_AW'(KEY_EXT_W'(key_r))),
    .wr_data (entry_upd)
  );

  // read-modify-write of the entry for sample items
  always_comb begin
    entry_upd = entry;
    wr_en     = 1'b0;
    if (state_r == ST_RMW) begin
      case (kind_r)
        KIND_IDLE: begin
          wr_en = 1'b1;
          if (reading_r < entry.idle_min) entry_upd.idle_min = reading_r;
          if (reading_r > entry.idle_max) entry_upd.idle_max = reading_r;
        end
        KIND_PRESSED: begin
          wr_en = 1'b1;
          if (reading_r > entry.pressed_max) entry_upd.pressed_max = reading_r;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  // calibration levels from the entry just read
  always_comb begin
    noise_raw = entry.idle_max - entry.idle_min;
    noise     = (noise_raw == '0) ? RD_W'(1) : noise_raw;
    pmax      = (entry.pressed_max < entry.idle_max) ? entry.idle_max : entry.pressed_max;
    half      = noise >> 1;
    low_v     = entry.idle_max - half;
    high_v    = pmax - half;
    diff      = {1'b0, high_v} - {1'b0, low_v};
  end

  // divider gets the magnitude of the difference and applies the sign itself
  always_comb begin
    div_req.start   = (state_r == ST_RMW) && (kind_r == KIND_COMPUTE);
    div_req.neg     = diff[RD_W];
    div_req.mag     = diff[RD_W] ? RD_W'(-diff) : diff[RD_W-1:0];
    div_req.divisor = noise;
  end

  ksnc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign load_out = (state_r == ST_DIV) && !div_busy && out_free;

  always_comb begin
    if (quotient > good_thr_r) begin
      grade_v = GRADE_GOOD;
    end else if (quotient > fair_thr_r) begin
      grade_v = GRADE_FAIR;
    end else begin
      grade_v = GRADE_POOR;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (rd_en) state_nxt = ST_RMW;
      end
      ST_RMW: begin
        state_nxt = (kind_r == KIND_COMPUTE) ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      good_thr_r  <= GOOD_RESET;
      fair_thr_r  <= FAIR_RESET;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_GOOD_SNR: good_thr_r <= cfg_ch.data;
          REG_FAIR_SNR: fair_thr_r <= cfg_ch.data;
          default: begin
            good_thr_r <= good_thr_r;
          end
        endcase
      end
    end
  end

  // item and operand capture, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r    <= in_ch.kind;
      key_r     <= in_ch.key;
      reading_r <= in_ch.reading;
    end
    if (div_req.start) begin
      low_r   <= low_v;
      high_r  <= high_v;
      noise_r <= noise;
    end
    if (load_out) begin
      out_key_r   <= key_r;
      out_low_r   <= low_r;
      out_high_r  <= high_r;
      out_noise_r <= noise_r;
      out_snr_r   <= quotient;
      out_grade_r <= grade_v;
    end
  end

  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.key_out     = out_key_r;
  assign out_ch.low_level   = out_low_r;
  assign out_ch.high_level  = out_high_r;
  assign out_ch.noise_level = out_noise_r;
  assign out_ch.snr         = out_snr_r;
  assign out_ch.grade       = out_grade_r;

endmodule
`default_nettype wire
